[design/qte_pkg.sv]
// Shared types, widths, constants and the CORDIC angle table for the quaternion to Euler block.
package qte_pkg;

    localparam int IN_W                  = 16;
    localparam int WORK_W                = 35;
    localparam int S_W                   = 30;
    localparam int SQ_W                  = 58;
    localparam int RAD_W                 = 57;
    localparam int ROOT_W                = 29;
    localparam int TRIAL_W               = 60;
    localparam int CORDIC_W              = 37;
    localparam int ANG_W                 = 28;
    localparam int ANG_TABLE_LEN         = 24;
    localparam int DEF_CORDIC_ITERATIONS = 16;
    localparam int QUEUE_DEPTH           = 2;
    localparam int ROLL_W                = 16;
    localparam int PITCH_W               = 15;
    localparam int ROLL_LIMIT            = 25736;
    localparam int PITCH_LIMIT           = 12868;

    localparam logic signed [ANG_W-1:0]  ANG_PI  = 28'sd52707179;
    localparam logic signed [WORK_W-1:0] ONE_Q28 = 35'sd268435456;
    localparam logic [RAD_W-1:0]         ONE_Q56 = 57'd1 << 56;

    // One request after the product stage, queued for the back end.
    typedef struct packed {
        logic signed [WORK_W-1:0] rn;
        logic signed [WORK_W-1:0] rd;
        logic signed [WORK_W-1:0] yn;
        logic signed [WORK_W-1:0] yd;
        logic signed [S_W-1:0]    s;
        logic                     clamped;
    } t_work;

    // atan(2^-i) scaled by 2^24, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            20: v = 28'sd16;
            21: v = 28'sd8;
            22: v = 28'sd4;
            23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/qte_front.sv]
// Front end: accepts quaternions, forms the product sums and clamps the pitch sine.
module qte_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [qte_pkg::IN_W-1:0] i_q_w,
    input  logic signed [qte_pkg::IN_W-1:0] i_q_x,
    input  logic signed [qte_pkg::IN_W-1:0] i_q_y,
    input  logic signed [qte_pkg::IN_W-1:0] i_q_z,
    input  logic                        i_full,
    output logic                        o_stall,
    output logic                        o_push,
    output qte_pkg::t_work              o_work
);
    import qte_pkg::*;

    localparam int P_W = 2 * IN_W;

    logic                   en;
    logic                   r_v1, r_v2;
    logic signed [P_W-1:0]  r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    t_work                  r_work, n_work;
    logic signed [WORK_W-1:0] sv;

    // The whole front advances whenever the queue has room.
    assign en      = !i_full;
    assign o_stall = i_full;
    assign o_push  = en && r_v2;
    assign o_work  = r_work;

    // Valid bits of the two front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: all nine products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_q_w * i_q_x;
            r_yz <= i_q_y * i_q_z;
            r_xx <= i_q_x * i_q_x;
            r_yy <= i_q_y * i_q_y;
            r_wz <= i_q_w * i_q_z;
            r_xy <= i_q_x * i_q_y;
            r_zz <= i_q_z * i_q_z;
            r_wy <= i_q_w * i_q_y;
            r_zx <= i_q_z * i_q_x;
        end
    end

    // Stage two: sums, doubled, and the saturated pitch sine.
    always_comb begin
        n_work.rn = (WORK_W'(r_wx) + WORK_W'(r_yz)) <<< 1;
        n_work.rd = ONE_Q28 - ((WORK_W'(r_xx) + WORK_W'(r_yy)) <<< 1);
        n_work.yn = (WORK_W'(r_wz) + WORK_W'(r_xy)) <<< 1;
        n_work.yd = ONE_Q28 - ((WORK_W'(r_yy) + WORK_W'(r_zz)) <<< 1);
        sv        = (WORK_W'(r_wy) - WORK_W'(r_zx)) <<< 1;
        if (sv > ONE_Q28) begin
            n_work.s       = S_W'(ONE_Q28);
            n_work.clamped = 1'b1;
        end else if (sv < -ONE_Q28) begin
            n_work.s       = S_W'(-ONE_Q28);
            n_work.clamped = 1'b1;
        end else begin
            n_work.s       = S_W'(sv);
            n_work.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_work <= n_work;
        end
    end

endmodule

[design/qte_fifo.sv]
// Short queue that decouples the front end from the back end.
module qte_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qte_pkg::t_work i_work,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output qte_pkg::t_work o_work
);
    import qte_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage is written only; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[design/qte_cordic.sv]
// Pipelined vectoring CORDIC: atan2(y, x) with one stage per iteration.
module qte_cordic #(
    parameter int ITERATIONS = qte_pkg::DEF_CORDIC_ITERATIONS,
    parameter int OUT_W      = qte_pkg::ROLL_W,
    parameter int LIMIT      = qte_pkg::ROLL_LIMIT
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [qte_pkg::CORDIC_W-1:0] i_x,
    input  logic signed [qte_pkg::CORDIC_W-1:0] i_y,
    output logic signed [OUT_W-1:0]             o_angle
);
    import qte_pkg::*;

    localparam int N = (ITERATIONS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : ITERATIONS;
    localparam logic signed [ANG_W:0] LIM_P = (ANG_W + 1)'(LIMIT);
    localparam logic signed [ANG_W:0] LIM_N = -LIM_P;

    logic signed [CORDIC_W-1:0] r_x [N+1];
    logic signed [CORDIC_W-1:0] r_y [N+1];
    logic signed [ANG_W-1:0]    r_z [N+1];
    logic                       r_zero [N+1];

    // Entry stage: fold the left half plane over and preset the angle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [CORDIC_W-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + atan_entry(i);
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - atan_entry(i);
                end
            end
        end
    end

    // Round to Q3.13 and saturate; a zero vector gives angle zero.
    logic signed [ANG_W:0] rnd, sh;
    assign rnd = (ANG_W + 1)'(r_z[N]) + (ANG_W + 1)'(1024);
    assign sh  = rnd >>> 11;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[N]) begin
                o_angle <= '0;
            end else if (sh > LIM_P) begin
                o_angle <= OUT_W'(LIM_P);
            end else if (sh < LIM_N) begin
                o_angle <= OUT_W'(LIM_N);
            end else begin
                o_angle <= OUT_W'(sh);
            end
        end
    end

endmodule

[design/qte_back.sv]
// Back end: pitch cosine by pipelined square root, then three CORDIC pipelines.
module qte_back #(
    parameter int CORDIC_ITERATIONS = qte_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  qte_pkg::t_work                      i_work,
    output logic                                o_pop,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [qte_pkg::ROLL_W-1:0]   o_roll_angle,
    output logic signed [qte_pkg::PITCH_W-1:0]  o_pitch_angle,
    output logic signed [qte_pkg::ROLL_W-1:0]   o_yaw_angle,
    output logic                                o_pitch_clamped
);
    import qte_pkg::*;

    localparam int N  = (CORDIC_ITERATIONS > ANG_TABLE_LEN) ? ANG_TABLE_LEN
                                                            : CORDIC_ITERATIONS;
    localparam int CL = N + 2;
    localparam int VL = 1 + ROOT_W + CL;

    logic                en;
    logic                r_vld [VL];
    t_work               r_sq_work;
    logic [SQ_W-1:0]     r_sq;
    logic [ROOT_W-1:0]   s_abs;
    logic [RAD_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    t_work               r_work [ROOT_W];
    logic                r_clamp [CL];
    t_work               last;

    // The whole back end holds while a finished result waits.
    assign en          = !(r_vld[VL-1] && i_out_stall);
    assign o_pop       = en && !i_empty;
    assign o_out_valid = r_vld[VL-1];

    // Valid chain through every back-end stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VL; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= !i_empty;
            for (int k = 1; k < VL; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Square of the pitch sine.
    assign s_abs = (i_work.s < 0) ? ROOT_W'(-i_work.s) : ROOT_W'(i_work.s);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_work <= i_work;
            r_sq      <= s_abs * s_abs;
        end
    end

    // Restoring square root of 2^56 - s^2, one result bit per stage.
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int K = ROOT_W - 1 - j;
        logic [RAD_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        t_work              work_in;
        logic [TRIAL_W-1:0] trial;

        if (j == 0) begin : g_first
            assign rem_in  = ONE_Q56 - r_sq[RAD_W-1:0];
            assign root_in = '0;
            assign work_in = r_sq_work;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign work_in = r_work[j-1];
        end

        assign trial = (TRIAL_W'(root_in) << (K + 1)) + (TRIAL_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_work[j] <= work_in;
                if (TRIAL_W'(rem_in) >= trial) begin
                    r_rem[j]  <= rem_in - RAD_W'(trial);
                    r_root[j] <= root_in | (ROOT_W'(1) << K);
                end else begin
                    r_rem[j]  <= rem_in;
                    r_root[j] <= root_in;
                end
            end
        end
    end

    assign last = r_work[ROOT_W-1];

    // Clamp flag rides alongside the CORDIC pipelines.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clamp[0] <= last.clamped;
            for (int k = 1; k < CL; k++) begin
                r_clamp[k] <= r_clamp[k-1];
            end
        end
    end
    assign o_pitch_clamped = r_clamp[CL-1];

    qte_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .OUT_W      (ROLL_W),
        .LIMIT      (ROLL_LIMIT)
    ) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (CORDIC_W'(last.rd)),
        .i_y     (CORDIC_W'(last.rn)),
        .o_angle (o_roll_angle)
    );

    qte_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .OUT_W      (PITCH_W),
        .LIMIT      (PITCH_LIMIT)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (CORDIC_W'(r_root[ROOT_W-1])),
        .i_y     (CORDIC_W'(last.s)),
        .o_angle (o_pitch_angle)
    );

    qte_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .OUT_W      (ROLL_W),
        .LIMIT      (ROLL_LIMIT)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (CORDIC_W'(last.yd)),
        .i_y     (CORDIC_W'(last.yn)),
        .o_angle (o_yaw_angle)
    );

endmodule

[design/quaternion_to_euler_angles.sv]
// Top level: quaternion (Q2.14) to ZYX Euler angles (Q3.13 radians).
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_q_w, i_q_x, i_q_y, i_q_z
//  output    out        o_out_valid / i_out_stall  o_roll_angle, o_pitch_angle,
//                                                  o_yaw_angle, o_pitch_clamped
//
// One request is accepted every cycle while neither side stalls.
// Requests pass through the front stages, the queue, the squaring stage, the 29-stage
// square root and the CORDIC stages, one per iteration of N = min(CORDIC_ITERATIONS, 24).
// Reset is synchronous and active low; it clears valid bits, queue pointers and fill count only.
// A stalled result holds the back end; the 2-entry queue then lets the front keep going until it fills.
module quaternion_to_euler_angles #(
    parameter int CORDIC_ITERATIONS = qte_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [qte_pkg::IN_W-1:0]     i_q_w,
    input  logic signed [qte_pkg::IN_W-1:0]     i_q_x,
    input  logic signed [qte_pkg::IN_W-1:0]     i_q_y,
    input  logic signed [qte_pkg::IN_W-1:0]     i_q_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [qte_pkg::ROLL_W-1:0]   o_roll_angle,
    output logic signed [qte_pkg::PITCH_W-1:0]  o_pitch_angle,
    output logic signed [qte_pkg::ROLL_W-1:0]   o_yaw_angle,
    output logic                                o_pitch_clamped
);
    import qte_pkg::*;

    logic  push, pop, full, empty;
    t_work front_work, queue_work;

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_q_w   (i_q_w),
        .i_q_x   (i_q_x),
        .i_q_y   (i_q_y),
        .i_q_z   (i_q_z),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_work  (front_work)
    );

    qte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_work  (queue_work)
    );

    qte_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_work          (queue_work),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_roll_angle    (o_roll_angle),
        .o_pitch_angle   (o_pitch_angle),
        .o_yaw_angle     (o_yaw_angle),
        .o_pitch_clamped (o_pitch_clamped)
    );

endmodule

[tb/testbench.sv]
// Testbench for the quaternion to Euler angle converter: directed and random requests.
`timescale 1ns / 100ps

module testbench;
    import qte_pkg::*;

    localparam int ITERS       = DEF_CORDIC_ITERATIONS;
    localparam int LATENCY     = 2 + 1 + 1 + 29 + ITERS + 2;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  yaw;
        logic                      clamped;
    } t_angles;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [IN_W-1:0]    i_q_w, i_q_x, i_q_y, i_q_z;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [ROLL_W-1:0]  o_roll_angle;
    logic signed [PITCH_W-1:0] o_pitch_angle;
    logic signed [ROLL_W-1:0]  o_yaw_angle;
    logic                      o_pitch_clamped;

    t_angles  angles_due[$];
    int       mismatches = 0;
    int       cycles     = 0;
    bit       idle_on    = 1'b0;
    int       hold_cycles = 0;

    quaternion_to_euler_angles u_top (.*);

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Fixed-point atan2 by vectoring rotation, Q3.13 before saturation.
    function automatic longint rotate_atan2(longint y, longint x);
        longint acc;
        longint xs;
        longint ys;
        longint tab[ANG_TABLE_LEN];
        tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            acc = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITERS && i < ANG_TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; acc += tab[i];
            end else begin
                x -= ys; y += xs; acc -= tab[i];
            end
        end
        return (acc + 1024) >>> 11;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Floor square root by binary digit recurrence.
    function automatic longint floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // Euler angles for one quaternion request.
    function automatic t_angles euler_of(longint w, longint x, longint y, longint z);
        t_angles a;
        longint one;
        longint s;
        longint c;
        one = 64'sd1 << 28;
        s = 2 * (w * y - z * x);
        a.clamped = 1'b0;
        if (s > one) begin
            s = one; a.clamped = 1'b1;
        end else if (s < -one) begin
            s = -one; a.clamped = 1'b1;
        end
        c = floor_sqrt((64'd1 << 56) - 64'(s * s));
        a.roll  = ROLL_W'(clip(rotate_atan2(2 * (w * x + y * z),
                                            one - 2 * (x * x + y * y)), ROLL_LIMIT));
        a.pitch = PITCH_W'(clip(rotate_atan2(s, c), PITCH_LIMIT));
        a.yaw   = ROLL_W'(clip(rotate_atan2(2 * (w * z + x * y),
                                            one - 2 * (y * y + z * z)), ROLL_LIMIT));
        return a;
    endfunction

    // Send one request, with an optional idle burst first.
    task automatic send_quat(input logic signed [15:0] w, x, y, z);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_q_w <= w; i_q_x <= x; i_q_y <= y; i_q_z <= z;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        angles_due.push_back(euler_of(w, x, y, z));
    endtask

    task automatic go_quiet;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Field extremes, axis rotations and the saturated pitch argument.
    task automatic test_directed;
        logic signed [15:0] ext[5];
        ext = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd11585};
        send_quat(16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(16384, 0, 16384, 0);
        send_quat(-16384, 0, -16384, 0);
        send_quat(16384, 16384, -16384, 16384);
        send_quat(-16384, -16384, 16384, -16384);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_quat(0, 11585, 0, 11585);
        for (int i = 0; i < 8; i++)
            send_quat(ext[$urandom_range(0, 4)], ext[$urandom_range(0, 4)],
                      ext[$urandom_range(0, 4)], ext[$urandom_range(0, 4)]);
    endtask

    // Random unit-ish quaternions plus full-width noise.
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure;
        hold_cycles = 150;
        test_random(60);
    endtask

    // Receiver stall: random bursts, long hold-offs on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
            end else begin
                e = angles_due.pop_front();
                if (e.roll !== o_roll_angle || e.pitch !== o_pitch_angle ||
                    e.yaw !== o_yaw_angle || e.clamped !== o_pitch_clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                 e.roll, e.pitch, e.yaw, e.clamped, o_roll_angle,
                                 o_pitch_angle, o_yaw_angle, o_pitch_clamped);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_q_w <= '0; i_q_x <= '0; i_q_y <= '0; i_q_z <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        idle_on = 1'b1;
        test_random(300);
        test_backpressure();
        idle_on = 1'b0;
        test_random(170);
        go_quiet();
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/qte_pkg.sv
design/qte_front.sv
design/qte_fifo.sv
design/qte_cordic.sv
design/qte_back.sv
design/quaternion_to_euler_angles.sv
tb/testbench.sv
